@@ sv/apifr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package apifr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned ADDR_W  = 2;

  localparam logic [TOTAL_W-1:0] API_ID_OFFSET = TOTAL_W'(3);
  localparam logic [TOTAL_W-1:0] HDR_EXTRA     = TOTAL_W'(4);
  localparam logic [BYTE_W-1:0]  SUM_INIT      = 8'hFF;

  localparam logic [BYTE_W-1:0]  START_RST = 8'h7E;
  localparam logic [TOTAL_W-1:0] MIN_RST   = TOTAL_W'(5);
  localparam logic [TOTAL_W-1:0] MAX_RST   = TOTAL_W'(128);

  typedef enum logic [ADDR_W-1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_MIN_TOTAL  = 2'd1,
    CFG_MAX_TOTAL  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_GOOD    = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  start_byte;
    logic [TOTAL_W-1:0] min_total;
    logic [TOTAL_W-1:0] max_total;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic               stored;
    logic [TOTAL_W-1:0] position;
    logic [TOTAL_W-1:0] frame_length;
    logic [BYTE_W-1:0]  api_id;
  } result_t;

endpackage

`default_nettype wire

@@ sv/apifr_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module apifr_parser (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    take,
  input  wire  [7:0]             byte_in,
  input  apifr_pkg::cfg_t        cfg,
  output apifr_pkg::result_t     res
);
  import apifr_pkg::*;

  logic [TOTAL_W-1:0] count_r, count_nxt;
  logic [TOTAL_W-1:0] expected_r, expected_nxt;
  logic [BYTE_W-1:0]  len_hi_r, len_hi_nxt;
  logic [BYTE_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0]  api_r, api_nxt;
  logic [TOTAL_W-1:0] count_inc;
  logic [TOTAL_W-1:0] total_calc;

  assign count_inc  = count_r + TOTAL_W'(1);
  assign total_calc = TOTAL_W'({len_hi_r, byte_in}) + HDR_EXTRA;

  always_comb begin
    count_nxt    = count_r;
    expected_nxt = expected_r;
    len_hi_nxt   = len_hi_r;
    sum_nxt      = sum_r;
    api_nxt      = api_r;
    res          = '{status: ST_NONE, stored: 1'b0, position: '0,
                     frame_length: '0, api_id: '0};
    if (count_r == TOTAL_W'(0)) begin
      if (byte_in == cfg.start_byte) begin
        res.stored = 1'b1;
        count_nxt  = TOTAL_W'(1);
        sum_nxt    = '0;
      end
    end else if (count_r == TOTAL_W'(1)) begin
      res.stored   = 1'b1;
      res.position = count_r;
      len_hi_nxt   = byte_in;
      count_nxt    = TOTAL_W'(2);
    end else if (count_r == TOTAL_W'(2)) begin
      res.stored   = 1'b1;
      res.position = count_r;
      expected_nxt = total_calc;
      if (total_calc < cfg.min_total || total_calc > cfg.max_total) begin
        res.status = ST_LEN_ERR;
        count_nxt  = '0;
      end else begin
        count_nxt  = TOTAL_W'(3);
      end
    end else begin
      res.stored   = 1'b1;
      res.position = count_r;
      if (count_r == API_ID_OFFSET) begin
        api_nxt = byte_in;
      end
      if (count_inc < expected_r) begin
        count_nxt = count_inc;
        sum_nxt   = sum_r + byte_in;
      end else begin
        // last word carries the checksum
        if (SUM_INIT - sum_r == byte_in) begin
          res.status       = ST_GOOD;
          res.frame_length = count_inc;
          res.api_id       = api_nxt;
        end
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      expected_r <= '0;
      len_hi_r   <= '0;
      sum_r      <= '0;
      api_r      <= '0;
    end else if (take) begin
      count_r    <= count_nxt;
      expected_r <= expected_nxt;
      len_hi_r   <= len_hi_nxt;
      sum_r      <= sum_nxt;
      api_r      <= api_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/apifr_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module apifr_out_reg (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    load,
  input  apifr_pkg::result_t     res_in,
  input  wire                    out_ready,
  output logic                   out_valid,
  output logic                   can_load,
  output apifr_pkg::result_t     res_out
);
  import apifr_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

endmodule

`default_nettype wire

@@ sv/api_frame_receiver_checksum_unit.sv @@
// Frame receiver with length check and 8-bit checksum.
// Input channel: one received word per transfer on in_byte_in (valid/ready).
// Output channel: exactly one result word per input word (valid/ready):
//   out_status (0 none or bad checksum, 1 length error, 2 good frame),
//   out_stored/out_position tell where the word sits in the frame so an
//   external buffer can hold it; out_frame_length and out_api_id are set
//   with a good frame only.
// Latency: a result is valid the cycle after its input word is taken.
// Throughput: one word per cycle unless stalled; the per-word parse is a
// single stage between the frame state registers and the result register.
// When the receiver stalls, the result register holds its word and the
// input is still taken in the same cycle the pending result is taken.
// Reset (synchronous, rst_n low): hunting for the start word, result
// register empty, registers back to start 0x7E, min total 5, max total 128.
// cfg_we writes a register at the edge; write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module api_frame_receiver_checksum_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [7:0]                   in_byte_in,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_status,
  output logic                         out_stored,
  output logic [16:0]                  out_position,
  output logic [16:0]                  out_frame_length,
  output logic [7:0]                   out_api_id,
  input  wire                          cfg_we,
  input  wire  [apifr_pkg::ADDR_W-1:0] cfg_addr,
  input  wire  [apifr_pkg::CFG_W-1:0]  cfg_wdata
);
  import apifr_pkg::*;

  cfg_t    cfg_r;
  result_t res_calc;
  result_t res_q;
  logic    take;

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= START_RST;
      cfg_r.min_total  <= MIN_RST;
      cfg_r.max_total  <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_START_BYTE: cfg_r.start_byte <= cfg_wdata[BYTE_W-1:0];
        CFG_MIN_TOTAL:  cfg_r.min_total  <= cfg_wdata[TOTAL_W-1:0];
        CFG_MAX_TOTAL:  cfg_r.max_total  <= cfg_wdata[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  apifr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_in (in_byte_in),
    .cfg     (cfg_r),
    .res     (res_calc)
  );

  apifr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res_in    (res_calc),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (in_ready),
    .res_out   (res_q)
  );

  assign out_status       = res_q.status;
  assign out_stored       = res_q.stored;
  assign out_position     = res_q.position;
  assign out_frame_length = res_q.frame_length;
  assign out_api_id       = res_q.api_id;

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("no result after accepted word");

  a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_GOOD) |->
      (out_stored && out_frame_length == out_position + 17'd1))
    else $error("good frame length does not match position");

  a_len_err_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_LEN_ERR) |->
      (out_stored && out_position == 17'd2))
    else $error("length error not at low length word");

  a_unstored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stored) |->
      (out_position == 17'd0 && out_status == ST_NONE))
    else $error("unstored word carries frame data");
`endif

endmodule

`default_nettype wire
